FILE: rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants of the run-length sprite palette decoder.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    localparam logic [7:0] CTRL_END_LINE = 8'h80;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_CONTROL = 3'b010,
        MODE_OPAQUE  = 3'b100
    } mode_t;

    typedef struct packed {
        logic        kind;
        logic [11:0] pixel_x;
        logic [9:0]  pixel_y;
        logic        clipped;
        logic        in_range;
    } result_t;

endpackage

FILE: rtl/rle_sprite_palette_decoder.sv
// ----------------------------------------------------------------------------
// rle_sprite_palette_decoder
// Decodes run-length coded sprite bytes into palette-mapped pixel writes.
// ----------------------------------------------------------------------------
// A result passes through the decode register and then the output register.
// Throughput: one input word per cycle; the decode register and the output
// register each hold one result, so input stalls only when both are full.
// Reset clears the decode state and all valid flags; the palette memory is not
// cleared and holds unknown colours until each entry is loaded.
module rle_sprite_palette_decoder #(
    parameter int PALETTE_ENTRIES  = 256,
    parameter int TEXTURE_WIDTH    = 4096,
    parameter int MAX_FRAME_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // data_byte, red, green, blue, frame_height, origin_column, zero pad
    input  logic [rsp_pkg::S_TDATA_W-1:0]     s_tdata,
    // command
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_x, pixel_y, pixel_word, clipped, zero pad
    output logic [rsp_pkg::M_TDATA_W-1:0]     m_tdata,
    // kind
    output logic [0:0]                        m_tuser
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic              accept;
    logic              pal_we;
    logic              res_valid;
    logic              res_ready;
    rsp_pkg::result_t  res;
    logic [23:0]       pal_data;
    logic              kind_out;

    rsp_decoder #(
        .PALETTE_ENTRIES  (PALETTE_ENTRIES),
        .TEXTURE_WIDTH    (TEXTURE_WIDTH),
        .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
    ) u_decoder (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .command       (s_tuser),
        .data_byte     (s_tdata[7:0]),
        .frame_height  (s_tdata[42:32]),
        .origin_column (s_tdata[54:43]),
        .accept        (accept),
        .pal_we        (pal_we),
        .res_ready     (res_ready),
        .res_valid     (res_valid),
        .res           (res)
    );

    rsp_palette #(
        .ENTRIES (PALETTE_ENTRIES),
        .AW      (AW)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (s_tdata[AW-1:0]),
        .wr_data ({s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]}),
        .rd_en   (accept),
        .rd_addr (s_tdata[AW-1:0]),
        .rd_data (pal_data)
    );

    rsp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .pal_data  (pal_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (kind_out)
    );

    assign m_tuser = kind_out;

`ifndef SYNTHESIS
    a_finish_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("frame finished word carries pixel data");

    a_clip_column: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] && m_tdata[54] |-> m_tdata[11:0] == 12'(TEXTURE_WIDTH - 1))
        else $error("clipped pixel has wrong column");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> res_valid && m_tvalid && !m_tready)
        else $error("input stalled while a stage was free");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[29:22] == rsp_pkg::ALPHA_OPAQUE)
        else $error("pixel word lacks opaque alpha");
`endif

endmodule

FILE: rtl/rsp_palette.sv
// ----------------------------------------------------------------------------
// rsp_palette
// Palette memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rsp_palette #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [23:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [23:0]   rd_data
);

    logic [23:0] mem [ENTRIES];
    logic [23:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/rsp_decoder.sv
// ----------------------------------------------------------------------------
// rsp_decoder
// Command decode, run-length state and the first result register.
// ----------------------------------------------------------------------------
module rsp_decoder #(
    parameter int PALETTE_ENTRIES  = 256,
    parameter int TEXTURE_WIDTH    = 4096,
    parameter int MAX_FRAME_HEIGHT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic [7:0]          data_byte,
    input  logic [10:0]         frame_height,
    input  logic [11:0]         origin_column,
    output logic                accept,
    output logic                pal_we,
    input  logic                res_ready,
    output logic                res_valid,
    output rsp_pkg::result_t    res
);

    localparam int CW    = $clog2(TEXTURE_WIDTH + 1);
    localparam int SUM_W = ((CW > 12) ? CW : 12) + 1;
    localparam int RW    = $clog2(MAX_FRAME_HEIGHT);
    localparam int HW    = ((RW + 1) > 11) ? (RW + 1) : 11;
    localparam int YW    = (RW > 10) ? RW : 10;
    localparam logic [SUM_W-1:0] TW_S  = SUM_W'(TEXTURE_WIDTH);
    localparam logic [SUM_W-1:0] TW_M1 = SUM_W'(TEXTURE_WIDTH - 1);
    localparam logic [HW-1:0]    MFH_H = HW'(MAX_FRAME_HEIGHT);

    rsp_pkg::mode_t    mode_reg, mode_next;
    logic [6:0]        remain_reg, remain_next;
    logic [CW-1:0]     column_reg, column_next;
    logic [CW-1:0]     origin_reg, origin_next;
    logic [RW-1:0]     row_reg, row_next;
    logic              res_valid_reg, res_valid_next;
    rsp_pkg::result_t  res_reg, res_next;

    logic              in_range;
    logic [SUM_W-1:0]  origin_ext, origin_clamp;
    logic [SUM_W-1:0]  col_sum, col_clamp;
    logic [6:0]        col_step;
    logic [HW-1:0]     height_h;
    logic              clip;
    logic [SUM_W-1:0]  x_full;
    logic [YW-1:0]     y_ext;
    logic              produce;

    assign in_ready = !res_valid_reg || res_ready;
    assign accept   = in_valid && in_ready;
    assign in_range = {1'b0, data_byte} < 9'(PALETTE_ENTRIES);
    assign pal_we   = accept && (command == rsp_pkg::CMD_LOAD) && in_range;

    always_comb
    begin
        origin_ext   = SUM_W'(origin_column);
        origin_clamp = (origin_ext > TW_S) ? TW_S : origin_ext;
        col_step     = (mode_reg == rsp_pkg::MODE_OPAQUE) ? 7'd1 : data_byte[6:0];
        col_sum      = SUM_W'(column_reg) + SUM_W'(col_step);
        col_clamp    = (col_sum > TW_S) ? TW_S : col_sum;
        height_h     = (frame_height == 11'd0) ? HW'(1) : HW'(frame_height);
        if (height_h > MFH_H)
        begin
            height_h = MFH_H;
        end
        clip   = SUM_W'(column_reg) >= TW_S;
        x_full = clip ? TW_M1 : SUM_W'(column_reg);
        y_ext  = YW'(row_reg);
    end

    always_comb
    begin
        mode_next      = mode_reg;
        remain_next    = remain_reg;
        column_next    = column_reg;
        origin_next    = origin_reg;
        row_next       = row_reg;
        produce        = 1'b0;
        res_next       = '0;
        if (accept && (command == rsp_pkg::CMD_START))
        begin
            origin_next = origin_clamp[CW-1:0];
            column_next = origin_clamp[CW-1:0];
            row_next    = RW'(height_h - HW'(1));
            remain_next = '0;
            mode_next   = rsp_pkg::MODE_CONTROL;
        end
        else if (accept && (command == rsp_pkg::CMD_DATA))
        begin
            case (mode_reg)
                rsp_pkg::MODE_CONTROL:
                begin
                    if (data_byte == rsp_pkg::CTRL_END_LINE)
                    begin
                        if (row_reg == '0)
                        begin
                            mode_next     = rsp_pkg::MODE_IDLE;
                            produce       = 1'b1;
                            res_next.kind = 1'b1;
                        end
                        else
                        begin
                            row_next    = row_reg - RW'(1);
                            column_next = origin_reg;
                        end
                    end
                    else if (data_byte[7])
                    begin
                        column_next = col_clamp[CW-1:0];
                    end
                    else if (data_byte != 8'd0)
                    begin
                        remain_next = data_byte[6:0];
                        mode_next   = rsp_pkg::MODE_OPAQUE;
                    end
                end
                rsp_pkg::MODE_OPAQUE:
                begin
                    produce           = 1'b1;
                    res_next.pixel_x  = x_full[11:0];
                    res_next.pixel_y  = y_ext[9:0];
                    res_next.clipped  = clip;
                    res_next.in_range = in_range;
                    column_next       = col_clamp[CW-1:0];
                    remain_next       = remain_reg - 7'd1;
                    if (remain_reg == 7'd1)
                    begin
                        mode_next = rsp_pkg::MODE_CONTROL;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            res_valid_next = produce;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= rsp_pkg::MODE_IDLE;
            remain_reg    <= '0;
            column_reg    <= '0;
            origin_reg    <= '0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            remain_reg    <= remain_next;
            column_reg    <= column_next;
            origin_reg    <= origin_next;
            row_reg       <= row_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/rsp_out_stage.sv
// ----------------------------------------------------------------------------
// rsp_out_stage
// Output register that assembles the colour word and holds it under stall.
// ----------------------------------------------------------------------------
module rsp_out_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               res_valid,
    output logic                               res_ready,
    input  rsp_pkg::result_t                   res,
    input  logic [23:0]                        pal_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rsp_pkg::M_TDATA_W-1:0]      out_data,
    output logic                               out_user
);

    logic                              valid_reg, valid_next;
    logic [rsp_pkg::M_TDATA_W-1:0]     data_reg, data_next;
    logic                              user_reg;
    logic [23:0]                       rgb;
    logic [31:0]                       word;

    assign res_ready = !valid_reg || out_ready;

    always_comb
    begin
        rgb  = res.in_range ? pal_data : 24'd0;
        word = res.kind ? 32'd0 : {rgb[7:0], rgb[15:8], rgb[23:16], rsp_pkg::ALPHA_OPAQUE};
        data_next = {1'b0, res.clipped, word, res.pixel_y, res.pixel_x};
        if (res_valid && res_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= data_next;
            user_reg <= res.kind;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

endmodule

FILE: sim/rle_sprite_palette_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_sprite_palette_decoder_test
// Self-checking bench for the run-length sprite palette decoder. A behavioural
// predictor tracks the palette and the decode state for every accepted word
// and queues the expected pixel writes and frame ends, which are compared
// field by field with each word leaving the block, under random idling on
// both sides and a long output stall.
// ----------------------------------------------------------------------------
module rle_sprite_palette_decoder_test;

    localparam logic [1:0] CMD_RESERVED     = 2'd3;
    localparam logic       KIND_PIXEL       = 1'b0;
    localparam logic       KIND_FRAME_DONE  = 1'b1;
    localparam int         TEXTURE_WIDTH    = 4096;
    localparam int         MAX_FRAME_HEIGHT = 1024;
    localparam int         PALETTE_ENTRIES  = 256;
    localparam int         RANDOM_WORDS     = 1300;
    localparam int         LONG_HOLD        = 300;

    typedef struct packed {
        logic        kind;
        logic [11:0] pixel_x;
        logic [9:0]  pixel_y;
        logic [31:0] pixel_word;
        logic        clipped;
    } sprite_write_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [rsp_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]                    s_tuser = rsp_pkg::CMD_LOAD;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rsp_pkg::M_TDATA_W-1:0] m_tdata;
    logic [0:0]                    m_tuser;

    // Predictor state.
    logic [23:0]     palette_rgb [PALETTE_ENTRIES];
    rsp_pkg::mode_t  decode_mode;
    logic [6:0]      opaque_left;
    logic [12:0]     cur_column;
    logic [11:0]     frame_origin;
    logic [9:0]      cur_row;

    sprite_write_t expected_writes[$];
    int            mismatch_count = 0;
    int            words_sent = 0;
    int            hold_cycles = 0;
    bit            sender_eager = 1'b0;
    bit            receiver_eager = 1'b0;

    rle_sprite_palette_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", expected_writes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [12:0] clamp_column(input logic [13:0] c);
        return (c > TEXTURE_WIDTH) ? 13'(TEXTURE_WIDTH) : c[12:0];
    endfunction

    task automatic predict_word(input logic [1:0] cmd,
                                input logic [rsp_pkg::S_TDATA_W-1:0] word);
        logic [7:0]    code;
        logic [10:0]   height;
        logic [23:0]   rgb;
        sprite_write_t res;
        code = word[7:0];
        res = '0;
        if (cmd == rsp_pkg::CMD_LOAD)
        begin
            palette_rgb[code] = {word[15:8], word[23:16], word[31:24]};
        end
        else if (cmd == rsp_pkg::CMD_START)
        begin
            height = word[42:32];
            if (height == 0)
                height = 11'd1;
            if (height > MAX_FRAME_HEIGHT)
                height = 11'(MAX_FRAME_HEIGHT);
            frame_origin = word[54:43];
            cur_column = clamp_column({2'b00, frame_origin});
            cur_row = 10'(height - 11'd1);
            opaque_left = '0;
            decode_mode = rsp_pkg::MODE_CONTROL;
        end
        else if (cmd == rsp_pkg::CMD_DATA && decode_mode == rsp_pkg::MODE_CONTROL)
        begin
            if (code == rsp_pkg::CTRL_END_LINE)
            begin
                if (cur_row == 0)
                begin
                    decode_mode = rsp_pkg::MODE_IDLE;
                    res.kind = KIND_FRAME_DONE;
                    expected_writes.push_back(res);
                end
                else
                begin
                    cur_row = cur_row - 10'd1;
                    cur_column = clamp_column({2'b00, frame_origin});
                end
            end
            else if (code[7])
                cur_column = clamp_column({1'b0, cur_column} + {7'd0, code[6:0]});
            else if (code != 0)
            begin
                opaque_left = code[6:0];
                decode_mode = rsp_pkg::MODE_OPAQUE;
            end
        end
        else if (cmd == rsp_pkg::CMD_DATA && decode_mode == rsp_pkg::MODE_OPAQUE)
        begin
            rgb = palette_rgb[code];
            res.kind = KIND_PIXEL;
            res.clipped = (cur_column >= TEXTURE_WIDTH);
            res.pixel_x = res.clipped ? 12'(TEXTURE_WIDTH - 1) : cur_column[11:0];
            res.pixel_y = cur_row;
            res.pixel_word = {rgb[7:0], rgb[15:8], rgb[23:16], rsp_pkg::ALPHA_OPAQUE};
            expected_writes.push_back(res);
            cur_column = clamp_column({1'b0, cur_column} + 14'd1);
            opaque_left = opaque_left - 7'd1;
            if (opaque_left == 0)
                decode_mode = rsp_pkg::MODE_CONTROL;
        end
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] code,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [10:0] height,
                             input logic [11:0] origin);
        int                            gap;
        logic [rsp_pkg::S_TDATA_W-1:0] word;
        gap = sender_eager ? 0 : $urandom_range(0, 7);
        word = {1'b0, origin, height, blue, green, red, code};
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= word;
        do
            @(posedge clk);
        while (!s_tready);
        predict_word(cmd, word);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] code);
        send_item(rsp_pkg::CMD_DATA, code, 8'($urandom), 8'($urandom), 8'($urandom),
                  11'($urandom), 12'($urandom));
    endtask

    task automatic send_start(input logic [10:0] height, input logic [11:0] origin);
        send_item(rsp_pkg::CMD_START, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), height, origin);
    endtask

    task automatic wait_drained;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
    endtask

    // Sends one opaque run of the given length with random palette indexes.
    task automatic send_run(input int len);
        send_byte(8'(len));
        repeat (len) send_byte(8'($urandom));
    endtask

    // Sends one coded frame; now and then the frame is broken off early or
    // carries a stray byte.
    task automatic send_frame;
        int          height;
        int          segments;
        logic [11:0] origin;
        height = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        origin = ($urandom_range(0, 3) == 0) ? 12'(4095 - $urandom_range(0, 40))
                                             : 12'($urandom);
        send_start(11'(height), origin);
        for (int r = 0; r < height; r++)
        begin
            segments = $urandom_range(0, 4);
            for (int s = 0; s < segments; s++)
            begin
                case ($urandom_range(0, 9))
                    0: send_byte(8'h00);
                    1, 2, 3: send_byte(8'h80 | 8'($urandom_range(1, 127)));
                    4: send_run($urandom_range(20, 127));
                    default: send_run($urandom_range(1, 12));
                endcase
                if ($urandom_range(0, 49) == 0)
                    send_byte(8'($urandom));
            end
            if ($urandom_range(0, 29) == 0)
                return;
            send_byte(rsp_pkg::CTRL_END_LINE);
        end
    endtask

    task automatic send_noise;
        repeat ($urandom_range(1, 6))
            send_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 11'($urandom), 12'($urandom));
    endtask

    task automatic test_palette_load;
        send_item(rsp_pkg::CMD_LOAD, 8'd0, 8'h00, 8'h00, 8'h00, 11'($urandom),
                  12'($urandom));
        send_item(rsp_pkg::CMD_LOAD, 8'd255, 8'hFF, 8'hFF, 8'hFF, 11'($urandom),
                  12'($urandom));
        for (int i = 1; i < PALETTE_ENTRIES - 1; i++)
            send_item(rsp_pkg::CMD_LOAD, 8'(i), 8'($urandom), 8'($urandom),
                      8'($urandom), 11'($urandom), 12'($urandom));
        wait_drained();
    endtask

    task automatic test_directed;
        send_byte(8'h05);
        send_item(CMD_RESERVED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 12'hFFF);
        send_start(11'd0, 12'd0);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'd0);
        send_byte(8'd255);
        send_byte(rsp_pkg::CTRL_END_LINE);
        send_start(11'd2047, 12'd4090);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'd17);
        send_byte(8'd200);
        send_start(11'd1024, 12'd4095);
        send_byte(8'h02);
        send_byte(8'd255);
        send_byte(8'd1);
        send_byte(rsp_pkg::CTRL_END_LINE);
        send_byte(8'h01);
        send_byte(8'd128);
        send_start(11'd1, 12'd0);
        send_byte(8'h81);
        send_byte(rsp_pkg::CTRL_END_LINE);
        send_byte(rsp_pkg::CTRL_END_LINE);
        wait_drained();
    endtask

    task automatic test_output_stall;
        sender_eager = 1'b1;
        hold_cycles = LONG_HOLD;
        send_start(11'd2, 12'd100);
        send_run(127);
        send_byte(rsp_pkg::CTRL_END_LINE);
        send_run(64);
        send_byte(rsp_pkg::CTRL_END_LINE);
        sender_eager = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_frames;
        while (words_sent < RANDOM_WORDS)
        begin
            sender_eager = ($urandom_range(0, 4) == 0);
            receiver_eager = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) == 0)
                send_noise();
            else
                send_frame();
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
        sender_eager = 1'b0;
        receiver_eager = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = receiver_eager ? 0 : $urandom_range(0, 7);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        sprite_write_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_writes.size() == 0)
                report_mismatch($sformatf("unexpected word kind=%0d tdata=%h",
                                          m_tuser, m_tdata));
            else
            begin
                exp_w = expected_writes.pop_front();
                if (m_tuser[0] !== exp_w.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, exp_w.kind));
                if (m_tdata[11:0] !== exp_w.pixel_x)
                    report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                              m_tdata[11:0], exp_w.pixel_x));
                if (m_tdata[21:12] !== exp_w.pixel_y)
                    report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                              m_tdata[21:12], exp_w.pixel_y));
                if (m_tdata[53:22] !== exp_w.pixel_word)
                    report_mismatch($sformatf("pixel_word %h, expected %h",
                                              m_tdata[53:22], exp_w.pixel_word));
                if (m_tdata[54] !== exp_w.clipped)
                    report_mismatch($sformatf("clipped %0d, expected %0d",
                                              m_tdata[54], exp_w.clipped));
            end
        end
    end

    initial
    begin
        decode_mode = rsp_pkg::MODE_IDLE;
        opaque_left = '0;
        cur_column = '0;
        frame_origin = '0;
        cur_row = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_palette_load();
        test_directed();
        test_output_stall();
        test_random_frames();
        repeat (20) @(posedge clk);
        if (expected_writes.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_writes.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: rle_sprite_palette_decoder.f
rtl/rsp_pkg.sv
rtl/rsp_palette.sv
rtl/rsp_decoder.sv
rtl/rsp_out_stage.sv
rtl/rle_sprite_palette_decoder.sv
sim/rle_sprite_palette_decoder_test.sv
